/* design/qrle_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrle_pkg
// Shared types, constants and the run-closing function of the quantized
// run-length encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qrle_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned BufDepth = 6;
  localparam int unsigned BufIdxW  = 3;
  localparam int unsigned DivSteps = 8;

  typedef logic [ByteW-1:0] byte_t;

  localparam byte_t MaxRun        = 8'd255;
  localparam byte_t ModeMarker    = 8'd0;
  localparam byte_t RunOne        = 8'd1;
  localparam byte_t FactorReset   = 8'd5;
  localparam logic  EnableReset   = 1'b1;

  // Configuration register indexes
  typedef enum logic {
    CFG_QUANT_FACTOR = 1'b0,
    CFG_QUANT_ENABLE = 1'b1
  } cfg_index_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_PLAN,
    S_EMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic div_step;
    logic quantize;
    logic plan;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic plan_empty;
    logic emit_last;
    logic out_free;
  } status_t;

  typedef struct packed {
    byte_t [2:0] bytes;
    logic  [1:0] n;
    logic        mode;
  } close_t;

  // Code one closed run: count c of value v, starting from the given mode.
  function automatic close_t close_run(input byte_t v, input byte_t c, input logic mode);
    close_t r;
    r.bytes = '0;
    r.n     = 2'd0;
    r.mode  = mode;
    if (c > RunOne) begin
      if (!mode) begin
        r.bytes[0] = ModeMarker;
        r.bytes[1] = c;
        r.bytes[2] = v;
        r.n        = 2'd3;
      end else begin
        r.bytes[0] = c;
        r.bytes[1] = v;
        r.n        = 2'd2;
      end
      r.mode = 1'b1;
    end else if (v == ModeMarker) begin
      // literal zero goes out as a run of one
      if (mode) begin
        r.bytes[0] = RunOne;
        r.bytes[1] = v;
        r.n        = 2'd2;
      end else begin
        r.bytes[0] = ModeMarker;
        r.bytes[1] = RunOne;
        r.bytes[2] = v;
        r.n        = 2'd3;
        r.mode     = 1'b1;
      end
    end else if (mode) begin
      r.bytes[0] = ModeMarker;
      r.bytes[1] = v;
      r.n        = 2'd2;
      r.mode     = 1'b0;
    end else begin
      r.bytes[0] = v;
      r.n        = 2'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/quantized_run_length_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantized_run_length_encoder
// Quantizes pixel bytes and codes them as literal and run segments.
// ----------------------------------------------------------------------------
// Each accepted pixel byte passes through these steps in order: the accept,
// the bit-serial restoring divider for floor(x/quant_factor), the multiply
// back, planning of the output bytes it produces (one to six, or none), and
// then one byte per cycle into the output register, slowed by any output
// back-pressure (a pixel that only extends a run finds nothing to send, and
// the encoder returns to idle). The next pixel is accepted while the last
// encoded byte still waits in the output register. Configuration writes are
// always taken at once and must only happen while the encoder is idle.
`default_nettype none

module quantized_run_length_encoder
  import qrle_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  // configuration write
  input  wire        cfg_valid_i,
  output logic       cfg_ready_o,
  input  wire        cfg_index_i,
  input  wire  [7:0] cfg_data_i,
  // pixel items
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire  [7:0] s_axis_tdata,   // [7:0] sample
  input  wire        s_axis_tlast,   // frame_last
  // encoded items
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [0:0] m_axis_tuser,   // [0] item_last
  output logic       m_axis_tlast    // frame_done
);

  byte_t   factor_q;
  logic    enable_q;
  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FactorReset;
      enable_q <= EnableReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_QUANT_FACTOR: factor_q <= cfg_data_i;
        CFG_QUANT_ENABLE: enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  qrle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  qrle_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .sample_i       (s_axis_tdata),
    .frame_last_i   (s_axis_tlast),
    .quant_factor_i (factor_q),
    .quant_enable_i (enable_q),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_byte_o     (m_axis_tdata),
    .item_last_o    (m_axis_tuser[0]),
    .frame_done_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* design/qrle_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrle_ctrl
// Sequencer of the encoder: accept, divide, quantize, plan the output
// bytes, then drain them one per free output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module qrle_ctrl
  import qrle_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.quantize = 1'b1;
        state_d        = S_PLAN;
      end
      S_PLAN: begin
        cmd_o.plan = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.plan_empty) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (status_i.emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* design/qrle_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrle_dpath
// Datapath: restoring divider, quantizing multiply, run state, planned
// byte buffer and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qrle_dpath
  import qrle_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire cmd_t        cmd_i,
  output status_t          status_o,
  input  wire  [ByteW-1:0] sample_i,
  input  wire              frame_last_i,
  input  wire  [ByteW-1:0] quant_factor_i,
  input  wire              quant_enable_i,
  input  wire              out_ready_i,
  output logic             out_valid_o,
  output logic [ByteW-1:0] out_byte_o,
  output logic             item_last_o,
  output logic             frame_done_o
);

  // item registers
  byte_t                sample_q;
  logic                 last_q;
  byte_t                dvd_q;     // dividend bits, then quotient
  byte_t                rem_q;
  logic [BufIdxW-1:0]   step_q;
  byte_t                x_q;

  // run state
  byte_t pend_q, pend_d;
  logic  has_q, has_d;
  byte_t run_q, run_d;
  logic  mode_q, mode_d;

  // planned bytes
  byte_t [BufDepth-1:0] buf_q, buf_d;
  logic [BufIdxW-1:0]   n_q, n_d;
  logic [BufIdxW-1:0]   idx_q;

  logic                 out_valid_q;
  byte_t                out_byte_q;
  logic                 item_last_q;
  logic                 frame_done_q;

  // one restoring divide step
  logic [ByteW:0] rem_shift;
  logic           q_bit;
  byte_t          rem_next;
  logic [2*ByteW-1:0] product;

  always_comb begin
    rem_shift = {rem_q, dvd_q[ByteW-1]};
    q_bit     = (rem_shift >= {1'b0, quant_factor_i});
    rem_next  = q_bit ? ByteW'(rem_shift - {1'b0, quant_factor_i}) : rem_shift[ByteW-1:0];
    product   = dvd_q * quant_factor_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sample_q <= sample_i;
      last_q   <= frame_last_i;
      dvd_q    <= sample_i;
      rem_q    <= '0;
      step_q   <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q  <= {dvd_q[ByteW-2:0], q_bit};
      rem_q  <= rem_next;
      step_q <= step_q + BufIdxW'(1);
    end
    if (cmd_i.quantize) begin
      x_q <= (quant_enable_i && (quant_factor_i != '0)) ? product[ByteW-1:0] : sample_q;
    end
  end

  // plan: at most two runs close per item
  close_t             c1, c2;
  logic               match, do_c1;
  logic [1:0]         n1, n2;
  byte_t              pend1, run1;
  logic               mode1;
  logic [BufIdxW-1:0] ii, jj;

  always_comb begin
    match  = has_q && (x_q == pend_q);
    do_c1  = has_q && (!match || (run_q == MaxRun));
    c1     = close_run(pend_q, run_q, mode_q);
    n1     = do_c1 ? c1.n : 2'd0;
    mode1  = do_c1 ? c1.mode : mode_q;
    pend1  = x_q;
    run1   = (match && (run_q != MaxRun)) ? run_q + 8'd1 : RunOne;

    c2     = close_run(pend1, run1, mode1);
    n2     = last_q ? c2.n : 2'd0;

    pend_d = pend1;
    has_d  = !last_q;
    run_d  = last_q ? RunOne : run1;
    mode_d = last_q ? 1'b0 : mode1;
    n_d    = {1'b0, n1} + {1'b0, n2};

    for (int i = 0; i < BufDepth; i++) begin
      ii = BufIdxW'(i);
      jj = ii - {1'b0, n1};
      if (ii < {1'b0, n1}) begin
        buf_d[i] = c1.bytes[ii[1:0]];
      end else if (jj < {1'b0, n2}) begin
        buf_d[i] = c2.bytes[jj[1:0]];
      end else begin
        buf_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      has_q  <= 1'b0;
      run_q  <= RunOne;
      mode_q <= 1'b0;
      n_q    <= '0;
      idx_q  <= '0;
    end else if (cmd_i.plan) begin
      pend_q <= pend_d;
      has_q  <= has_d;
      run_q  <= run_d;
      mode_q <= mode_d;
      n_q    <= n_d;
      idx_q  <= '0;
    end else if (cmd_i.load_out) begin
      idx_q <= idx_q + BufIdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.plan) begin
      buf_q <= buf_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_byte_q   <= buf_q[idx_q];
      item_last_q  <= status_o.emit_last;
      frame_done_q <= status_o.emit_last && last_q;
    end
  end

  always_comb begin
    status_o.div_done   = (step_q == BufIdxW'(DivSteps - 1));
    status_o.plan_empty = (n_q == '0);
    status_o.emit_last  = (idx_q == n_q - BufIdxW'(1));
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign item_last_o  = item_last_q;
  assign frame_done_o = frame_done_q;

endmodule

`default_nettype wire

/* verif/quantized_run_length_encoder_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantized_run_length_encoder_test
// Self-checking bench for the quantized run-length encoder. Pixel frames go in
// through the slave stream and encoded bytes come back on the master stream.
// A cycle-free predictor tracks the held value, run length and coding mode and
// queues the encoded bytes each accepted pixel produces. Every returned byte is
// matched against that queue. Both stream sides idle in random bursts until the last
// phase, and the quantizer settings change between phases while the encoder sits idle.
// ----------------------------------------------------------------------------

module quantized_run_length_encoder_test;
  import qrle_pkg::*;

  typedef struct packed {
    byte_t sample;
    logic  eof;
  } pixel_t;

  typedef struct packed {
    byte_t code;
    logic  item_end;
    logic  frame_end;
  } code_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  cfg_index_e  cfg_index_i   = CFG_QUANT_FACTOR;
  byte_t       cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  byte_t       s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;

  quantized_run_length_encoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] sample
    .s_axis_tlast  (s_axis_tlast),   // frame_last
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte
    .m_axis_tuser  (m_axis_tuser),   // [0] item_last
    .m_axis_tlast  (m_axis_tlast)    // frame_done
  );

  // Predictor state and its copy of the registers
  byte_t       cur_qfac     = FactorReset;
  logic        cur_qen      = EnableReset;
  byte_t       held_val     = '0;
  logic        held         = 1'b0;
  byte_t       held_len     = 8'd1;
  logic        in_run_mode  = 1'b0;
  byte_t       seg_q[$];
  code_t       code_q[$];

  pixel_t      pixel_q[$];
  pixel_t      drv_px;
  int unsigned n_sent       = 0;
  int unsigned n_accepted   = 0;
  int unsigned n_codes      = 0;
  int unsigned n_frames     = 0;
  int unsigned n_errors     = 0;
  int unsigned src_gap      = 0;
  int unsigned sink_gap     = 0;
  logic        idle_en      = 1'b1;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Timeout: %0d of %0d pixels taken, %0d bytes still due",
             n_accepted, n_sent, code_q.size());
    $display("Regression FAIL");
    $finish;
  end

  function automatic void note_error(string what);
    n_errors++;
    if (n_errors <= 10) $display("ERROR @%0t: %s", $realtime, what);
  endfunction

  // Code one closed run of count c with value v into seg_q.
  function automatic void close_segment(byte_t v, byte_t c);
    if (c > RunOne) begin
      if (!in_run_mode) seg_q.push_back(ModeMarker);
      in_run_mode = 1'b1;
      seg_q.push_back(c);
      seg_q.push_back(v);
    end else begin
      if (v == ModeMarker) begin
        // a lone zero always goes out as a run of one
        if (in_run_mode) begin
          seg_q.push_back(RunOne);
        end else begin
          seg_q.push_back(ModeMarker);
          seg_q.push_back(RunOne);
          in_run_mode = 1'b1;
        end
      end else if (in_run_mode) begin
        in_run_mode = 1'b0;
        seg_q.push_back(ModeMarker);
      end
      seg_q.push_back(v);
    end
  endfunction

  function automatic void encode_pixel(byte_t raw, logic eof);
    byte_t x;
    code_t c;
    x = raw;
    if (cur_qen && cur_qfac != 8'd0) x = (x / cur_qfac) * cur_qfac;
    seg_q.delete();
    if (held && x == held_val) begin
      if (held_len < MaxRun) begin
        held_len++;
      end else begin
        close_segment(held_val, held_len);
        held_len = 8'd1;
      end
    end else begin
      if (held) close_segment(held_val, held_len);
      held_val = x;
      held_len = 8'd1;
      held     = 1'b1;
    end
    if (eof) begin
      // close the frame as if a different byte followed, then start fresh
      close_segment(held_val, held_len);
      held        = 1'b0;
      held_len    = 8'd1;
      in_run_mode = 1'b0;
      n_frames++;
    end
    foreach (seg_q[i]) begin
      c.code      = seg_q[i];
      c.item_end  = (i == seg_q.size() - 1);
      c.frame_end = eof && (i == seg_q.size() - 1);
      code_q.push_back(c);
    end
  endfunction

  // Pixel driver: predict on acceptance, then load the next item or idle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        encode_pixel(drv_px.sample, drv_px.eof);
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (idle_en && pixel_q.size() > 0 && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 17);
          s_axis_tvalid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          drv_px = pixel_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= drv_px.sample;
          s_axis_tlast  <= drv_px.eof;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output back-pressure in random bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      sink_gap = $urandom_range(0, 17);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    code_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_codes++;
      if (code_q.size() == 0) begin
        note_error($sformatf("unexpected byte %02h user %b last %b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        want = code_q.pop_front();
        if (m_axis_tdata !== want.code || m_axis_tuser[0] !== want.item_end ||
            m_axis_tlast !== want.frame_end) begin
          note_error($sformatf("byte %0d: expected %02h/%b/%b, got %02h/%b/%b",
                               n_codes, want.code, want.item_end, want.frame_end,
                               m_axis_tdata, m_axis_tuser[0], m_axis_tlast));
        end
      end
    end
  end

  task automatic queue_pixel(byte_t s, logic eof);
    pixel_t p;
    p.sample = s;
    p.eof    = eof;
    pixel_q.push_back(p);
    n_sent++;
  endtask

  // Wait until every pixel is taken and every byte is back, then let the
  // encoder finish any pixel that produced nothing.
  task automatic settle();
    while (n_accepted != n_sent || code_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Write both registers back to back; valid stays high across the pair.
  task automatic apply_setting(byte_t fac, logic en);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_QUANT_FACTOR;
    cfg_data_i  <= fac;
    do @(posedge clk_i); while (!cfg_ready_o);
    cur_qfac = fac;
    cfg_index_i <= CFG_QUANT_ENABLE;
    cfg_data_i  <= {7'd0, en};
    do @(posedge clk_i); while (!cfg_ready_o);
    cur_qen = en;
    cfg_valid_i <= 1'b0;
  endtask

  // Whole frames built from short runs, with jitter in the low bits.
  task automatic random_frames(int unsigned n);
    int unsigned made;
    int unsigned flen;
    int unsigned pos;
    int unsigned reps;
    byte_t       v;
    byte_t       s;
    made = 0;
    while (made < n) begin
      flen = $urandom_range(1, 12);
      pos  = 0;
      while (pos < flen) begin
        case ($urandom_range(0, 3))
          0:       v = 8'h00;
          1:       v = 8'hFF;
          default: v = byte_t'($urandom_range(0, 255));
        endcase
        reps = $urandom_range(1, 5);
        repeat (reps) begin
          if (pos < flen) begin
            s = ($urandom_range(0, 3) == 0) ? v ^ byte_t'($urandom_range(0, 3)) : v;
            queue_pixel(s, pos == flen - 1);
            pos++;
          end
        end
      end
      made += flen;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: factor 5, quantizer on
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd254, 1'b0);
    queue_pixel(8'd0,   1'b0);
    queue_pixel(8'd1,   1'b0);
    queue_pixel(8'd4,   1'b0);
    queue_pixel(8'd10,  1'b0);
    queue_pixel(8'd0,   1'b0);
    queue_pixel(8'd128, 1'b0);
    queue_pixel(8'd170, 1'b0);
    queue_pixel(8'd85,  1'b0);
    queue_pixel(8'd3,   1'b1);
    queue_pixel(8'd0,   1'b1);
    queue_pixel(8'd200, 1'b1);
    queue_pixel(8'd9,   1'b0);
    queue_pixel(8'd9,   1'b0);
    queue_pixel(8'd9,   1'b1);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd0,   1'b0);
    queue_pixel(8'd255, 1'b1);
    settle();

    // Pass-through: one run long enough to split at the maximum count
    apply_setting(8'd255, 1'b0);
    repeat (259) queue_pixel(8'h5A, 1'b0);
    queue_pixel(8'h00, 1'b0);
    queue_pixel(8'hA5, 1'b1);
    settle();

    apply_setting(8'd255, 1'b1);
    random_frames(30);
    settle();

    // Zero factor leaves bytes untouched
    apply_setting(8'd0, 1'b1);
    queue_pixel(8'd0,   1'b0);
    queue_pixel(8'd1,   1'b0);
    queue_pixel(8'd2,   1'b0);
    queue_pixel(8'd3,   1'b0);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd254, 1'b1);
    settle();

    apply_setting(8'd1, 1'b1);
    random_frames(35);
    settle();

    apply_setting(byte_t'($urandom_range(2, 254)), 1'b1);
    random_frames(45);
    settle();

    // Last part runs at full rate on both sides
    idle_en = 1'b0;
    apply_setting(8'd7, 1'b1);
    random_frames(40);
    settle();

    if (code_q.size() != 0) note_error($sformatf("%0d bytes never came", code_q.size()));
    $display("Sent %0d pixels in %0d frames, checked %0d encoded bytes, %0d mismatches",
             n_accepted, n_frames, n_codes, n_errors);
    $display("Factors 0, 1, 5, 7, 255 and one random, quantizer on and off, runs past 255");
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
